[sv/eiec_pkg.sv]
// Package for the external interrupt edge controller.
// Holds the operation, port and register codes and the types shared by the lanes,
// the merge stage and the top level. It depends on nothing.
package eiec_pkg;

    localparam int FIELD_W       = 16;
    localparam int CODE_BITS     = 4;
    localparam int LINES_PER_SEL = 4;
    localparam int SEL_COUNT     = 4;
    localparam int NUM_PORTS     = 6;
    localparam int CFG_INDEX_W   = 3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [CODE_BITS-1:0] PORT_A = 4'd0;
    localparam logic [CODE_BITS-1:0] PORT_B = 4'd1;
    localparam logic [CODE_BITS-1:0] PORT_C = 4'd2;
    localparam logic [CODE_BITS-1:0] PORT_D = 4'd3;
    localparam logic [CODE_BITS-1:0] PORT_E = 4'd4;
    localparam logic [CODE_BITS-1:0] PORT_F = 4'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_INTERRUPT_MASK = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RISING_ENABLE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FALLING_ENABLE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT_SEL_0_3   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT_SEL_4_7   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT_SEL_8_11  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PORT_SEL_12_15 = 3'd6;

    typedef struct packed {
        logic accept;
        logic sample;
        logic primed;
    } lane_ctl_t;

    typedef struct packed {
        logic [FIELD_W-1:0] pending_bits;
        logic [FIELD_W-1:0] line_levels;
        logic               request_lines_0_1;
        logic               request_lines_2_3;
        logic               request_lines_4_15;
    } result_t;

endpackage

[sv/eiec_cmd_if.sv]
// Command channel of the external interrupt edge controller.
// Carries valid, ready and the fields of one command item; uses eiec_pkg.
interface eiec_cmd_if
    import eiec_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [FIELD_W-1:0] clear_mask;
    logic [FIELD_W-1:0] port_a_levels;
    logic [FIELD_W-1:0] port_b_levels;
    logic [FIELD_W-1:0] port_c_levels;
    logic [FIELD_W-1:0] port_d_levels;
    logic [FIELD_W-1:0] port_e_levels;
    logic [FIELD_W-1:0] port_f_levels;

    modport source (
        output valid, operation, clear_mask, port_a_levels, port_b_levels,
               port_c_levels, port_d_levels, port_e_levels, port_f_levels,
        input  ready
    );

    modport sink (
        input  valid, operation, clear_mask, port_a_levels, port_b_levels,
               port_c_levels, port_d_levels, port_e_levels, port_f_levels,
        output ready
    );
endinterface

[sv/eiec_result_if.sv]
// Result channel of the external interrupt edge controller.
// Carries valid, ready and the fields of one result item; uses eiec_pkg.
interface eiec_result_if
    import eiec_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] pending_bits;
    logic [FIELD_W-1:0] line_levels;
    logic               request_lines_0_1;
    logic               request_lines_2_3;
    logic               request_lines_4_15;

    modport source (
        output valid, pending_bits, line_levels, request_lines_0_1,
               request_lines_2_3, request_lines_4_15,
        input  ready
    );

    modport sink (
        input  valid, pending_bits, line_levels, request_lines_0_1,
               request_lines_2_3, request_lines_4_15,
        output ready
    );
endinterface

[sv/eiec_lane.sv]
// Edge detection lane for one interrupt line.
// Selects the pin level by port code, detects edges and keeps the line's
// stored level and pending bit; uses eiec_pkg.
module eiec_lane
    import eiec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctl_t            ctl,
    input  logic [NUM_PORTS-1:0] port_pins,
    input  logic [CODE_BITS-1:0] port_code,
    input  logic                 rise_en,
    input  logic                 fall_en,
    input  logic                 clear_bit,
    output logic                 level_next,
    output logic                 pend_next
);

    logic level_reg;
    logic pend_reg;
    logic pin_level;
    logic edge_hit;

    always_comb
    begin
        unique case (port_code)
            PORT_A:  pin_level = port_pins[0];
            PORT_B:  pin_level = port_pins[1];
            PORT_C:  pin_level = port_pins[2];
            PORT_D:  pin_level = port_pins[3];
            PORT_E:  pin_level = port_pins[4];
            PORT_F:  pin_level = port_pins[5];
            default: pin_level = 1'b0;
        endcase
    end

    assign edge_hit = ctl.primed
                    & ((pin_level & ~level_reg & rise_en) | (~pin_level & level_reg & fall_en));

    assign level_next = ctl.sample ? pin_level : level_reg;
    assign pend_next  = ctl.sample ? (pend_reg | edge_hit) : (pend_reg & ~clear_bit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (ctl.accept)
        begin
            level_reg <= level_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

[sv/eiec_merge.sv]
// Merge stage of the external interrupt edge controller.
// Combines the lane outputs into one result item with the grouped requests;
// uses eiec_pkg.
module eiec_merge
    import eiec_pkg::*;
#(
    parameter int LINE_COUNT = 16
)
(
    input  logic [LINE_COUNT-1:0] pend_vec,
    input  logic [LINE_COUNT-1:0] level_vec,
    input  logic [LINE_COUNT-1:0] mask,
    output result_t               result
);

    logic [LINE_COUNT-1:0] req;
    logic                  req_high;

    assign req = pend_vec & mask;

    generate
        if (LINE_COUNT > 4)
        begin : g_high
            assign req_high = |req[LINE_COUNT-1:4];
        end
        else
        begin : g_no_high
            assign req_high = 1'b0;
        end
    endgenerate

    always_comb
    begin
        result.pending_bits       = FIELD_W'(pend_vec);
        result.line_levels        = FIELD_W'(level_vec);
        result.request_lines_0_1  = |req[1:0];
        result.request_lines_2_3  = |req[3:2];
        result.request_lines_4_15 = req_high;
    end

endmodule

[sv/external_interrupt_edge_controller.sv]
// External interrupt edge controller: LINE_COUNT lines, each watching one pin chosen
// from six ports, with rising and falling triggers, write-one-to-clear pending bits
// and three masked request groups. It takes one item per clock cycle; the result of
// an item appears in the output register on the next cycle, set by the single
// registered pass through the line lanes and the merge stage, and a new item is
// taken whenever that register is empty or being read in the same cycle.
// Configuration is written through cfg_write_enable, cfg_index and cfg_data.
// Depends on eiec_pkg, eiec_cmd_if, eiec_result_if, eiec_lane and eiec_merge.
module external_interrupt_edge_controller
    import eiec_pkg::*;
#(
    parameter int LINE_COUNT = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data,
    eiec_cmd_if.sink               command,
    eiec_result_if.source          result
);

    logic [LINE_COUNT-1:0] mask_reg;
    logic [LINE_COUNT-1:0] rise_en_reg;
    logic [LINE_COUNT-1:0] fall_en_reg;
    logic [FIELD_W-1:0]    port_sel_reg [SEL_COUNT];
    logic                  primed_reg;
    logic                  valid_reg;
    result_t               result_reg;
    result_t               result_next;

    logic                  accept;
    lane_ctl_t             ctl;
    logic [LINE_COUNT-1:0] level_vec;
    logic [LINE_COUNT-1:0] pend_vec;

    assign command.ready = !valid_reg || result.ready;
    assign accept        = command.valid && command.ready;

    assign ctl.accept = accept;
    assign ctl.sample = accept && (command.operation == OP_SAMPLE);
    assign ctl.primed = primed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            rise_en_reg <= '0;
            fall_en_reg <= '0;
            for (int s = 0; s < SEL_COUNT; s++)
            begin
                port_sel_reg[s] <= '0;
            end
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_INTERRUPT_MASK: mask_reg        <= cfg_data[LINE_COUNT-1:0];
                REG_RISING_ENABLE:  rise_en_reg     <= cfg_data[LINE_COUNT-1:0];
                REG_FALLING_ENABLE: fall_en_reg     <= cfg_data[LINE_COUNT-1:0];
                REG_PORT_SEL_0_3:   port_sel_reg[0] <= cfg_data;
                REG_PORT_SEL_4_7:   port_sel_reg[1] <= cfg_data;
                REG_PORT_SEL_8_11:  port_sel_reg[2] <= cfg_data;
                REG_PORT_SEL_12_15: port_sel_reg[3] <= cfg_data;
                default:            ;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < LINE_COUNT; i++)
        begin : g_lane
            eiec_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .port_pins  ({command.port_f_levels[i], command.port_e_levels[i],
                              command.port_d_levels[i], command.port_c_levels[i],
                              command.port_b_levels[i], command.port_a_levels[i]}),
                .port_code  (port_sel_reg[i / LINES_PER_SEL]
                                 [(i % LINES_PER_SEL) * CODE_BITS +: CODE_BITS]),
                .rise_en    (rise_en_reg[i]),
                .fall_en    (fall_en_reg[i]),
                .clear_bit  (command.clear_mask[i]),
                .level_next (level_vec[i]),
                .pend_next  (pend_vec[i])
            );
        end
    endgenerate

    eiec_merge #(
        .LINE_COUNT (LINE_COUNT)
    ) u_merge (
        .pend_vec  (pend_vec),
        .level_vec (level_vec),
        .mask      (mask_reg),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.sample)
            begin
                primed_reg <= 1'b1;
            end
            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid              = valid_reg;
    assign result.pending_bits       = result_reg.pending_bits;
    assign result.line_levels        = result_reg.line_levels;
    assign result.request_lines_0_1  = result_reg.request_lines_0_1;
    assign result.request_lines_2_3  = result_reg.request_lines_2_3;
    assign result.request_lines_4_15 = result_reg.request_lines_4_15;

    a_result_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> result.valid
    ) else $error("no result after an accepted item");

    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !valid_reg |-> command.ready
    ) else $error("command stalled while the output register is empty");

    a_clear_takes_effect: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && command.operation == OP_CLEAR)
            |=> (result.pending_bits & $past(command.clear_mask)) == '0
    ) else $error("cleared pending bits still set");

    a_no_phantom_lines: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.pending_bits >> LINE_COUNT) == '0
    ) else $error("pending bit set beyond the last line");

endmodule

[verif/external_interrupt_edge_controller_checker.sv]
`timescale 1ns / 1ps
// Result checker for the external interrupt edge controller test bench.
// Watches the configuration port and both channels, predicts every result item and
// compares it with what the block returns; depends on eiec_pkg, eiec_cmd_if and eiec_result_if.
module external_interrupt_edge_controller_checker
    import eiec_pkg::*;
#(
    parameter int LINE_COUNT = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]     cfg_data,
    eiec_cmd_if                    command,
    eiec_result_if                 result,
    output int                     mismatches,
    output int                     outstanding
);

    localparam logic [FIELD_W-1:0] LINE_SPAN = FIELD_W'((32'd1 << LINE_COUNT) - 32'd1);

    logic [FIELD_W-1:0] irq_mask;
    logic [FIELD_W-1:0] rise_en;
    logic [FIELD_W-1:0] fall_en;
    logic [FIELD_W-1:0] port_sel [SEL_COUNT];
    logic [FIELD_W-1:0] pending;
    logic [FIELD_W-1:0] prev_levels;
    logic               primed;
    result_t            expected_results [$];

    function automatic result_t apply_command(
        input logic                              op,
        input logic [FIELD_W-1:0]                clr,
        input logic [NUM_PORTS-1:0][FIELD_W-1:0] ports
    );
        logic [FIELD_W-1:0]   levels;
        logic [FIELD_W-1:0]   requests;
        logic [CODE_BITS-1:0] code;
        result_t              r;
        if (op == OP_SAMPLE)
        begin
            levels = '0;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                code = port_sel[i / LINES_PER_SEL][(i % LINES_PER_SEL) * CODE_BITS +: CODE_BITS];
                if (code < NUM_PORTS)
                begin
                    levels[i] = ports[code][i];
                end
            end
            if (primed)
            begin
                pending = pending | (((levels & ~prev_levels & rise_en)
                                      | (~levels & prev_levels & fall_en)) & LINE_SPAN);
            end
            prev_levels = levels;
            primed = 1'b1;
        end
        else
        begin
            pending = pending & ~clr;
        end
        pending = pending & LINE_SPAN;
        requests = pending & irq_mask & LINE_SPAN;
        r.pending_bits = pending;
        r.line_levels = prev_levels;
        r.request_lines_0_1 = |requests[1:0];
        r.request_lines_2_3 = |requests[3:2];
        r.request_lines_4_15 = |requests[FIELD_W-1:4];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t                           seen;
        result_t                           want;
        logic [NUM_PORTS-1:0][FIELD_W-1:0] ports;
        if (!rst_n)
        begin
            irq_mask = '0;
            rise_en = '0;
            fall_en = '0;
            for (int s = 0; s < SEL_COUNT; s++)
            begin
                port_sel[s] = '0;
            end
            pending = '0;
            prev_levels = '0;
            primed = 1'b0;
            expected_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                seen.pending_bits = result.pending_bits;
                seen.line_levels = result.line_levels;
                seen.request_lines_0_1 = result.request_lines_0_1;
                seen.request_lines_2_3 = result.request_lines_2_3;
                seen.request_lines_4_15 = result.request_lines_4_15;
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected result item, pending %h levels %h",
                                 $time, seen.pending_bits, seen.line_levels);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.pending_bits !== want.pending_bits
                        || seen.line_levels !== want.line_levels
                        || seen.request_lines_0_1 !== want.request_lines_0_1
                        || seen.request_lines_2_3 !== want.request_lines_2_3
                        || seen.request_lines_4_15 !== want.request_lines_4_15)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: expected pending %h levels %h requests %b%b%b",
                                     $time, want.pending_bits, want.line_levels,
                                     want.request_lines_0_1, want.request_lines_2_3,
                                     want.request_lines_4_15);
                            $display("%0t:      got pending %h levels %h requests %b%b%b",
                                     $time, seen.pending_bits, seen.line_levels,
                                     seen.request_lines_0_1, seen.request_lines_2_3,
                                     seen.request_lines_4_15);
                        end
                        mismatches++;
                    end
                end
            end
            if (command.valid && command.ready)
            begin
                ports[PORT_A] = command.port_a_levels;
                ports[PORT_B] = command.port_b_levels;
                ports[PORT_C] = command.port_c_levels;
                ports[PORT_D] = command.port_d_levels;
                ports[PORT_E] = command.port_e_levels;
                ports[PORT_F] = command.port_f_levels;
                expected_results.push_back(
                    apply_command(command.operation, command.clear_mask, ports));
            end
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    REG_INTERRUPT_MASK: irq_mask = cfg_data;
                    REG_RISING_ENABLE:  rise_en = cfg_data;
                    REG_FALLING_ENABLE: fall_en = cfg_data;
                    REG_PORT_SEL_0_3:   port_sel[0] = cfg_data;
                    REG_PORT_SEL_4_7:   port_sel[1] = cfg_data;
                    REG_PORT_SEL_8_11:  port_sel[2] = cfg_data;
                    REG_PORT_SEL_12_15: port_sel[3] = cfg_data;
                    default:            ;
                endcase
            end
            outstanding = expected_results.size();
        end
    end

endmodule

[verif/external_interrupt_edge_controller_test.sv]
`timescale 1ns / 1ps
// Top of the external interrupt edge controller test bench: clock, reset, configuration,
// command stimulus and result back-pressure, and the final verdict.
// Depends on eiec_pkg, both channel interfaces, the block and its result checker.
module external_interrupt_edge_controller_test
    import eiec_pkg::*;
();

    localparam int                     LINES           = 16;
    localparam int                     RANDOM_PHASES   = 8;
    localparam int                     ITEMS_PER_PHASE = 130;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED      = 3'd7;
    localparam logic [CODE_BITS-1:0]   CODE_FIRST_UNUSED = PORT_F + 4'd1;
    localparam logic [CODE_BITS-1:0]   CODE_LAST_UNUSED  = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_enable;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]     cfg_data;
    int                     mismatches;
    int                     outstanding;
    int                     stall_pct;
    bit                     sender_steady;

    eiec_cmd_if    command ();
    eiec_result_if result ();

    external_interrupt_edge_controller #(
        .LINE_COUNT(LINES)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .result          (result)
    );

    external_interrupt_edge_controller_checker #(
        .LINE_COUNT(LINES)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_enable(cfg_write_enable),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .result          (result),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [FIELD_W-1:0] random_field();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] random_select();
        logic [FIELD_W-1:0] value;
        case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = '1;
            default:
            begin
                for (int k = 0; k < LINES_PER_SEL; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        value[k*CODE_BITS +: CODE_BITS] =
                            CODE_BITS'($urandom_range(CODE_FIRST_UNUSED, CODE_LAST_UNUSED));
                    else
                        value[k*CODE_BITS +: CODE_BITS] =
                            CODE_BITS'($urandom_range(PORT_A, PORT_F));
                end
            end
        endcase
        return value;
    endfunction

    function automatic logic [NUM_PORTS-1:0][FIELD_W-1:0] random_ports();
        logic [NUM_PORTS-1:0][FIELD_W-1:0] ports;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            ports[p] = FIELD_W'($urandom);
        end
        return ports;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [FIELD_W-1:0] data);
        @(negedge clk);
        cfg_write_enable = 1'b1;
        cfg_index = index;
        cfg_data = data;
        @(negedge clk);
        cfg_write_enable = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        command.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_item(input logic op, input logic [FIELD_W-1:0] clr,
                             input logic [NUM_PORTS-1:0][FIELD_W-1:0] ports);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            command.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        command.valid = 1'b1;
        command.operation = op;
        command.clear_mask = clr;
        command.port_a_levels = ports[PORT_A];
        command.port_b_levels = ports[PORT_B];
        command.port_c_levels = ports[PORT_C];
        command.port_d_levels = ports[PORT_D];
        command.port_e_levels = ports[PORT_E];
        command.port_f_levels = ports[PORT_F];
        @(posedge clk);
        while (!command.ready)
            @(posedge clk);
    endtask

    task automatic randomize_config();
        write_reg(REG_INTERRUPT_MASK, random_field());
        write_reg(REG_RISING_ENABLE, random_field());
        write_reg(REG_FALLING_ENABLE, random_field());
        write_reg(REG_PORT_SEL_0_3, random_select());
        write_reg(REG_PORT_SEL_4_7, random_select());
        write_reg(REG_PORT_SEL_8_11, random_select());
        write_reg(REG_PORT_SEL_12_15, random_select());
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, random_field());
    endtask

    initial
    begin
        int stall_left;
        result.ready = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result.ready = 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        logic [NUM_PORTS-1:0][FIELD_W-1:0] pins;
        logic [FIELD_W-1:0]                clr;
        logic                              op;
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        command.valid = 1'b0;
        command.operation = OP_SAMPLE;
        command.clear_mask = '0;
        command.port_a_levels = '0;
        command.port_b_levels = '0;
        command.port_c_levels = '0;
        command.port_d_levels = '0;
        command.port_e_levels = '0;
        command.port_f_levels = '0;
        stall_pct = 10;
        sender_steady = 1'b0;
        pins = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // All lines on port A with both triggers; the first sample must only prime.
        write_reg(REG_INTERRUPT_MASK, '1);
        write_reg(REG_RISING_ENABLE, '1);
        write_reg(REG_FALLING_ENABLE, '1);
        write_reg(REG_PORT_SEL_0_3, '0);
        write_reg(REG_PORT_SEL_4_7, '0);
        write_reg(REG_PORT_SEL_8_11, '0);
        write_reg(REG_PORT_SEL_12_15, '0);
        write_reg(REG_UNUSED, '1);
        send_item(OP_SAMPLE, '1, {{(NUM_PORTS-1){16'h0000}}, 16'hFFFF});
        send_item(OP_SAMPLE, '1, {NUM_PORTS{16'h0000}});
        send_item(OP_CLEAR, 16'h0003, {NUM_PORTS{16'hFFFF}});
        send_item(OP_CLEAR, 16'h000C, random_ports());
        send_item(OP_CLEAR, 16'hFFF0, random_ports());
        send_item(OP_SAMPLE, '0, {{(NUM_PORTS-1){16'h0000}}, 16'hFFFF});
        send_item(OP_CLEAR, 16'hFFFF, {NUM_PORTS{16'hFFFF}});
        wait_idle();

        // Every port and unused codes; the select change itself makes edges.
        write_reg(REG_PORT_SEL_0_3, {PORT_D, PORT_C, PORT_B, PORT_A});
        write_reg(REG_PORT_SEL_4_7, {CODE_FIRST_UNUSED + 4'd1, CODE_FIRST_UNUSED, PORT_F, PORT_E});
        write_reg(REG_PORT_SEL_8_11, {LINES_PER_SEL{CODE_LAST_UNUSED}});
        write_reg(REG_PORT_SEL_12_15, {PORT_C, CODE_LAST_UNUSED, PORT_A, CODE_FIRST_UNUSED});
        write_reg(REG_INTERRUPT_MASK, 16'h0010);
        write_reg(REG_RISING_ENABLE, 16'hAAAA);
        write_reg(REG_FALLING_ENABLE, 16'h5555);
        send_item(OP_SAMPLE, '0, {NUM_PORTS{16'hFFFF}});
        send_item(OP_SAMPLE, '0, {NUM_PORTS{16'h0000}});
        send_item(OP_SAMPLE, '0, {16'h0020, 16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001});
        send_item(OP_CLEAR, '0, {NUM_PORTS{16'hFFFF}});
        send_item(OP_SAMPLE, '0, random_ports());
        send_item(OP_CLEAR, '1, {NUM_PORTS{16'h0000}});

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            randomize_config();
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 5;
                2:       stall_pct = 20;
                default: stall_pct = 50;
            endcase
            sender_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 3 && n == ITEMS_PER_PHASE / 2)
                    wait_idle();
                op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_SAMPLE;
                clr = random_field();
                case ($urandom_range(0, 19))
                    0: pins = '0;
                    1: pins = '1;
                    default:
                    begin
                        for (int p = 0; p < NUM_PORTS; p++)
                        begin
                            case ($urandom_range(0, 3))
                                0: pins[p] = FIELD_W'($urandom);
                                1: pins[p] = pins[p] ^ (16'h0001 << $urandom_range(0, FIELD_W - 1));
                                2: ;
                                default: pins[p] = pins[p] ^ FIELD_W'($urandom & $urandom);
                            endcase
                        end
                    end
                endcase
                send_item(op, clr, pins);
            end
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
